// File: design/ccs_pkg.sv
`default_nettype none
package ccs_pkg;

    localparam int MAX_LEN = 256;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // character codes
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_LBRK   = 8'h5B;
    localparam logic [7:0] C_RBRK   = 8'h5D;
    localparam logic [7:0] C_LBRC   = 8'h7B;
    localparam logic [7:0] C_RBRC   = 8'h7D;
    localparam logic [7:0] C_LT     = 8'h3C;
    localparam logic [7:0] C_GT     = 8'h3E;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_AMP    = 8'h26;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_PIPE   = 8'h7C;
    localparam logic [7:0] C_EQ     = 8'h3D;
    localparam logic [7:0] C_HASH   = 8'h23;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_COLON  = 8'h3A;
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_LPAR   = 8'h28;
    localparam logic [7:0] C_RPAR   = 8'h29;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_DQUOTE = 8'h22;

    // how the back end spells out one decided character
    typedef enum logic [1:0] {
        K_PLAIN, // ch
        K_PAREN, // ' ' ch ' '
        K_SET    // ' ' '(' ' ' ch ' '
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       last;
        logic       too_long;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic [1:0] used;
    } t_dec;

    // decide the head of a window holding avail (1..3) characters
    function automatic t_dec decide(input logic [7:0] w0, input logic [7:0] w1,
                                    input logic [7:0] w2, input logic [1:0] avail);
        logic [7:0] b;
        logic [7:0] c;
        t_dec       d;
        b = (avail >= 2'd2) ? w1 : 8'h00;
        c = (avail == 2'd3) ? w2 : 8'h00;
        d.kind = K_PLAIN;
        d.ch   = w0;
        d.used = 2'd1;
        if (w0 == C_COMMA) begin
            d.ch = C_SPACE;
        end else if (w0 == C_LBRK) begin
            d.kind = K_SET;
            d.ch   = C_SQUOTE;
        end else if (w0 == C_LBRC) begin
            d.kind = K_SET;
            d.ch   = C_DQUOTE;
        end else if (w0 == C_RBRC || w0 == C_RBRK || w0 == C_GT) begin
            d.kind = K_PAREN;
            d.ch   = C_RPAR;
        end else if (w0 == C_LT && b != C_MINUS) begin
            d.kind = K_PAREN;
            d.ch   = C_LPAR;
        end else if (avail >= 2'd2 && w0 == C_AMP && b == C_SLASH) begin
            d.ch   = C_HASH;
            d.used = 2'd2;
        end else if (avail >= 2'd2 && w0 == C_AMP && b == C_PIPE) begin
            d.ch   = C_SEMI;
            d.used = 2'd2;
        end else if (avail == 2'd3 && w0 == C_MINUS && b == C_MINUS && c == C_GT) begin
            d.ch   = C_COLON;
            d.used = 2'd3;
        end else if (avail == 2'd3 && w0 == C_LT && b == C_MINUS && c == C_GT) begin
            d.ch   = C_EQ;
            d.used = 2'd3;
        end else if (avail == 2'd3 && w0 == C_EQ && (b == C_SLASH || b == C_EQ)
                     && c == C_GT) begin
            d.ch   = C_DOLLAR;
            d.used = 2'd3;
        end else if (w0 == C_LPAR || w0 == C_RPAR) begin
            d.kind = K_PAREN;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// File: design/ccs_in_if.sv
`default_nettype none
interface ccs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface
`default_nettype wire

// File: design/ccs_out_if.sv
`default_nettype none
interface ccs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_ch;
    logic       out_last;
    logic       too_long;

    modport source (output valid, output out_ch, output out_last, output too_long,
                    input ready);
    modport sink   (input valid, input out_ch, input out_last, input too_long,
                    output ready);
endinterface
`default_nettype wire

// File: design/ccs_front.sv
`default_nettype none
module ccs_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    ccs_in_if.sink               i_in,
    input  ccs_pkg::t_q_stat     i_stat,
    output logic                 o_push,
    output ccs_pkg::t_entry      o_entry
);

    logic [7:0]                r_win [0:1];
    logic [7:0]                n_win [0:1];
    logic [1:0]                r_cnt, n_cnt;
    logic                      r_flush, n_flush;
    logic [ccs_pkg::LEN_W-1:0] r_len, n_len;
    logic                      r_ovf, n_ovf;

    logic [7:0]                cw0, cw1, cw2;
    logic [1:0]                cn;
    logic                      fin;
    logic                      acc;
    logic                      do_dec;
    logic [1:0]                rem;
    logic [7:0]                s0, s1;
    logic [ccs_pkg::LEN_W-1:0] len_inc;
    logic                      ovf_now;
    ccs_pkg::t_dec             dec;

    localparam logic [ccs_pkg::LEN_W-1:0] LenMax = ccs_pkg::LEN_W'(ccs_pkg::MAX_LEN);
    localparam logic [ccs_pkg::LEN_W-1:0] OvfAt  = ccs_pkg::LEN_W'(ccs_pkg::MAX_LEN - 2);

    assign i_in.ready = !r_flush && !i_stat.full;
    assign acc        = i_in.valid && i_in.ready;

    // build the window: held characters plus the incoming one, or only the held ones while flushing
    always_comb begin
        cw0 = r_win[0];
        cw1 = r_win[1];
        cw2 = 8'h00;
        cn  = r_cnt;
        fin = 1'b1;
        if (!r_flush) begin
            cn  = 2'(r_cnt + 2'd1);
            fin = i_in.last;
            case (r_cnt)
                2'd0: cw0 = i_in.ch;
                2'd1: cw1 = i_in.ch;
                2'd2: cw2 = i_in.ch;
                default: cw2 = i_in.ch;
            endcase
        end
    end

    assign dec    = ccs_pkg::decide(cw0, cw1, cw2, cn);
    assign do_dec = r_flush ? !i_stat.full : (acc && (cn == 2'd3 || i_in.last));
    assign rem    = 2'(cn - dec.used);

    always_comb begin
        case (dec.used)
            2'd1: begin
                s0 = cw1;
                s1 = cw2;
            end
            2'd2: begin
                s0 = cw2;
                s1 = 8'h00;
            end
            default: begin
                s0 = 8'h00;
                s1 = 8'h00;
            end
        endcase
    end

    assign len_inc = (r_len < LenMax) ? ccs_pkg::LEN_W'(r_len + 1'b1) : r_len;
    assign ovf_now = acc ? (r_ovf || len_inc >= OvfAt) : r_ovf;

    always_comb begin
        n_win   = r_win;
        n_cnt   = r_cnt;
        n_flush = r_flush;
        n_len   = r_len;
        n_ovf   = ovf_now;
        if (acc) begin
            n_len = i_in.last ? '0 : len_inc;
        end
        if (do_dec) begin
            n_win[0] = s0;
            n_win[1] = s1;
            n_cnt    = rem;
            n_flush  = fin && (rem != 2'd0);
        end else if (acc) begin
            n_win[0] = cw0;
            n_win[1] = cw1;
            n_cnt    = cn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= 8'h00;
            r_win[1] <= 8'h00;
            r_cnt    <= 2'd0;
            r_flush  <= 1'b0;
            r_len    <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_win   <= n_win;
            r_cnt   <= n_cnt;
            r_flush <= n_flush;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
        end
    end

    assign o_push           = do_dec;
    assign o_entry.kind     = dec.kind;
    assign o_entry.ch       = dec.ch;
    assign o_entry.last     = fin && (rem == 2'd0);
    assign o_entry.too_long = ovf_now;

endmodule
`default_nettype wire

// File: design/ccs_fifo.sv
`default_nettype none
module ccs_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  ccs_pkg::t_entry      i_entry,
    input  wire logic            i_pop,
    output ccs_pkg::t_entry      o_entry,
    output ccs_pkg::t_q_stat     o_stat
);

    ccs_pkg::t_entry         r_mem [ccs_pkg::Q_DEPTH];
    logic [ccs_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [ccs_pkg::Q_AW:0]   r_cnt;

    localparam logic [ccs_pkg::Q_AW:0] Depth = (ccs_pkg::Q_AW + 1)'(ccs_pkg::Q_DEPTH);

    assign o_stat.full  = (r_cnt == Depth);
    assign o_stat.empty = (r_cnt == '0);
    assign o_entry      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ccs_pkg::Q_AW'(r_wp + 1'b1);
            end
            if (i_pop) begin
                r_rp <= ccs_pkg::Q_AW'(r_rp + 1'b1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= (ccs_pkg::Q_AW + 1)'(r_cnt + 1'b1);
                2'b01:   r_cnt <= (ccs_pkg::Q_AW + 1)'(r_cnt - 1'b1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: design/ccs_back.sv
`default_nettype none
module ccs_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  ccs_pkg::t_entry      i_entry,
    input  ccs_pkg::t_q_stat     i_stat,
    output logic                 o_pop,
    ccs_out_if.source            o_out
);

    ccs_pkg::t_entry r_cur;
    logic [2:0]      r_phase, n_phase;
    logic            r_busy, n_busy;
    logic [2:0]      phase_end;
    logic            at_end;
    logic            xfer;

    always_comb begin
        case (r_cur.kind)
            ccs_pkg::K_PLAIN: phase_end = 3'd0;
            ccs_pkg::K_PAREN: phase_end = 3'd2;
            ccs_pkg::K_SET:   phase_end = 3'd4;
            default:          phase_end = 3'd0;
        endcase
    end

    assign at_end = (r_phase == phase_end);
    assign xfer   = o_out.valid && o_out.ready;
    assign o_pop  = !i_stat.empty && (!r_busy || (xfer && at_end));

    always_comb begin
        n_phase = r_phase;
        n_busy  = r_busy;
        if (o_pop) begin
            n_phase = 3'd0;
            n_busy  = 1'b1;
        end else if (xfer) begin
            if (at_end) begin
                n_busy = 1'b0;
            end else begin
                n_phase = 3'(r_phase + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 3'd0;
            r_busy  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_busy  <= n_busy;
        end
    end

    // spell out the held character with its padding
    always_comb begin
        o_out.out_ch = ccs_pkg::C_SPACE;
        case (r_cur.kind)
            ccs_pkg::K_PLAIN: o_out.out_ch = r_cur.ch;
            ccs_pkg::K_PAREN: begin
                if (r_phase == 3'd1) begin
                    o_out.out_ch = r_cur.ch;
                end
            end
            ccs_pkg::K_SET: begin
                if (r_phase == 3'd1) begin
                    o_out.out_ch = ccs_pkg::C_LPAR;
                end else if (r_phase == 3'd3) begin
                    o_out.out_ch = r_cur.ch;
                end
            end
            default: o_out.out_ch = r_cur.ch;
        endcase
    end

    assign o_out.valid    = r_busy;
    assign o_out.out_last = r_cur.last && at_end;
    assign o_out.too_long = r_cur.too_long;

endmodule
`default_nettype wire

// File: design/copula_canonicalizer_stream.sv
// Path: a decided character is registered in the queue, then in the back end's held entry.
// Throughput: one input character per cycle while the queue is not full and no flush runs;
// each decided character leaves as 1, 3 or 5 output characters, one per cycle while the
// output is ready, and a final character holds off input while the front end flushes its
// two-character look-ahead window into the queue. Reset: synchronous, active low; clears
// the window, length count, overflow flag, queue pointers and the output stage.
`default_nettype none
module copula_canonicalizer_stream (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ccs_in_if.sink     i_in,
    ccs_out_if.source  o_out
);

    logic             q_push;
    logic             q_pop;
    ccs_pkg::t_entry  q_wr_entry;
    ccs_pkg::t_entry  q_rd_entry;
    ccs_pkg::t_q_stat q_stat;

    ccs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (q_stat),
        .o_push  (q_push),
        .o_entry (q_wr_entry)
    );

    ccs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .i_pop   (q_pop),
        .o_entry (q_rd_entry),
        .o_stat  (q_stat)
    );

    ccs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (q_rd_entry),
        .i_stat  (q_stat),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

    a_no_push_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    a_no_pop_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_too_long_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && $past(o_out.valid && o_out.ready && o_out.too_long))
        |-> o_out.too_long)
        else $error("overflow flag dropped");

endmodule
`default_nettype wire
